@@ sv/tiled_floyd_steinberg_dither_unit_macros.svh @@
// assertion macros shared by the tiled dither unit rtl
// expects a clock named clock and a synchronous reset named reset in scope
`ifndef TILED_FLOYD_STEINBERG_DITHER_UNIT_MACROS_SVH
`define TILED_FLOYD_STEINBERG_DITHER_UNIT_MACROS_SVH

// same-cycle implication
`define TFSD_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TFSD_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tfsd_pkg.sv @@
// types, constants and per-channel dither arithmetic for the tiled dither unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tfsd_pkg;

   localparam int LEVEL_W    = 8;
   localparam int CSR_W      = 7;
   localparam int ACC_W      = 13;
   localparam int E_W        = 9;
   localparam int WANT_W     = 10;
   localparam int MIN_TILE   = 2;
   localparam int TILE_RESET = 8;
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = 1;
   localparam int Q_CNT_W    = 2;

   localparam logic signed [WANT_W-1:0] THRESH_LEVEL = 10'sd127;
   localparam logic signed [WANT_W-1:0] FULL_LEVEL   = 10'sd255;

   typedef struct packed {
      logic [LEVEL_W-1:0] gray_level;
      logic [LEVEL_W-1:0] alpha_level;
   } req_item_type;

   typedef struct packed {
      logic bw_pixel;
      logic opaque_bit;
      logic tile_done;
   } rsp_item_type;

   typedef struct packed {
      logic first_col;
      logic last_col;
      logic first_row;
      logic tile_done;
   } tile_flags_type;

   typedef struct packed {
      req_item_type   pix;
      tile_flags_type flags;
   } q_item_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] gray;
      logic signed [ACC_W-1:0] alpha;
   } err_pair_type;

   typedef struct packed {
      logic signed [E_W-1:0] gray;
      logic signed [E_W-1:0] alpha;
   } e_pair_type;

   typedef struct packed {
      logic                  bit_out;
      logic signed [E_W-1:0] err;
   } dith_type;

   function automatic logic signed [ACC_W-1:0] sext_err(input logic signed [E_W-1:0] e);
      sext_err = $signed({{(ACC_W-E_W){e[E_W-1]}}, e});
   endfunction

   // level plus 1/16 of accumulated error, truncated toward zero, then threshold
   function automatic dith_type dither_ch(
      input logic [LEVEL_W-1:0]      level,
      input logic signed [ACC_W-1:0] prev_row,
      input logic signed [E_W-1:0]   eprev
   );
      logic signed [ACC_W-1:0]  ext;
      logic signed [ACC_W-1:0]  sum;
      logic signed [ACC_W-1:0]  biased;
      logic signed [ACC_W-1:0]  quot;
      logic signed [WANT_W-1:0] want;
      dith_type                 res;
      ext    = sext_err(eprev);
      sum    = prev_row + (ext <<< 3) - ext;
      biased = sum + (sum[ACC_W-1] ? ACC_W'(15) : ACC_W'(0));
      quot   = biased >>> 4;
      want   = $signed(quot[WANT_W-1:0] + {{(WANT_W-LEVEL_W){1'b0}}, level});
      res.bit_out = (want > THRESH_LEVEL);
      if (res.bit_out) begin
         res.err = E_W'(want - FULL_LEVEL);
      end else begin
         res.err = E_W'(want);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ sv/tfsd_front.sv @@
// front part: takes pixels, tracks tile position, tags each transaction
// with row and column flags; holds the tile size register; uses tfsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfsd_front import tfsd_pkg::*; #(
   parameter int MAX_TILE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  req_item_type       req_item,
   output logic               req_full,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_wdata,
   output logic               q_push,
   output q_item_type         q_item,
   input  logic               q_full
);

   localparam int COL_W = $clog2(MAX_TILE);
   localparam int RST_EDGE = (TILE_RESET > MAX_TILE) ? MAX_TILE : TILE_RESET;
   localparam logic [COL_W-1:0] LAST_RST = COL_W'(RST_EDGE - 1);

   logic [COL_W-1:0] last_ff, last_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] wr_last;
   logic             accept;
   tile_flags_type   flags;

   always_comb begin
      if (csr_wdata < CSR_W'(MIN_TILE)) begin
         wr_last = COL_W'(MIN_TILE - 1);
      end else if (32'(csr_wdata) > MAX_TILE) begin
         wr_last = COL_W'(MAX_TILE - 1);
      end else begin
         wr_last = COL_W'(csr_wdata - CSR_W'(1));
      end
   end

   always_comb begin
      csr_ready       = 1'b1;
      req_full        = q_full;
      accept          = req_push && !q_full;
      flags.first_col = (col_ff == '0);
      flags.last_col  = (col_ff == last_ff);
      flags.first_row = (row_ff == '0);
      flags.tile_done = flags.last_col && (row_ff == last_ff);
      q_push          = accept;
      q_item.pix      = req_item;
      q_item.flags    = flags;
      last_in         = last_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      if (csr_valid) begin
         last_in = wr_last;
         col_in  = '0;
         row_in  = '0;
      end else if (accept) begin
         if (flags.last_col) begin
            col_in = '0;
            row_in = flags.tile_done ? '0 : row_ff + COL_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= LAST_RST;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         last_ff <= last_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/tfsd_queue.sv @@
// short queue between the front and back parts
// uses tfsd_pkg for the transaction type and depth
`timescale 1ns / 1ps
`default_nettype none

module tfsd_queue import tfsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_item_type push_item,
   output logic       full,
   input  logic       pop,
   output q_item_type pop_item,
   output logic       valid
);

   q_item_type         slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      full      = (count_ff == Q_CNT_W'(Q_DEPTH));
      valid     = (count_ff != '0);
      pop_item  = slot_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ sv/tfsd_back.sv @@
// back part: error line memory, dither arithmetic and result register
// uses tfsd_pkg and the assertion macros header
`timescale 1ns / 1ps
`default_nettype none
`include "tiled_floyd_steinberg_dither_unit_macros.svh"

module tfsd_back import tfsd_pkg::*; #(
   parameter int MAX_TILE = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  q_item_type   q_item,
   input  logic         q_valid,
   output logic         q_pop,
   output rsp_item_type rsp_item,
   output logic         rsp_empty,
   input  logic         rsp_pop
);

   localparam int COL_W = $clog2(MAX_TILE);

   err_pair_type     mem [MAX_TILE];
   err_pair_type     rd_ff, fwd_data_ff;
   logic             fwd_ff;
   logic             s1_valid_ff, s1_valid_in;
   q_item_type       s1_item_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [COL_W-1:0] rd_addr, wr_addr;
   logic             load, advance, wr_en;
   err_pair_type     wr_data, prev_row;
   err_pair_type     p_ff, p_in, q_ff, q_in, tail_ff, tail_in;
   e_pair_type       eprev_ff, e_use;
   dith_type         g_res, a_res;
   logic signed [ACC_W-1:0] ext_g, ext_a;
   logic             out_valid_ff, out_valid_in;
   rsp_item_type     out_ff, out_in;

   always_comb begin
      advance     = s1_valid_ff && (!out_valid_ff || rsp_pop);
      load        = q_valid && (!s1_valid_ff || advance);
      q_pop       = load;
      rd_addr     = q_item.flags.first_col ? '0 : s1_col_ff + COL_W'(1);
      s1_valid_in = load || (s1_valid_ff && !advance);

      // error carried down from the previous row, zero on the first row
      if (s1_item_ff.flags.first_row) begin
         prev_row = '0;
      end else if (s1_item_ff.flags.last_col) begin
         prev_row = tail_ff;
      end else if (fwd_ff) begin
         prev_row = fwd_data_ff;
      end else begin
         prev_row = rd_ff;
      end
      e_use = s1_item_ff.flags.first_col ? '0 : eprev_ff;

      g_res = dither_ch(s1_item_ff.pix.gray_level, prev_row.gray, e_use.gray);
      a_res = dither_ch(s1_item_ff.pix.alpha_level, prev_row.alpha, e_use.alpha);
      ext_g = sext_err(g_res.err);
      ext_a = sext_err(a_res.err);

      // 3/16 closes the column to the left, 5/16 and 1/16 stay in flight
      wr_data.gray  = p_ff.gray + (ext_g <<< 1) + ext_g;
      wr_data.alpha = p_ff.alpha + (ext_a <<< 1) + ext_a;
      wr_en         = advance && !s1_item_ff.flags.first_col;
      wr_addr       = s1_col_ff - COL_W'(1);
      p_in.gray     = (s1_item_ff.flags.first_col ? '0 : q_ff.gray) + (ext_g <<< 2) + ext_g;
      p_in.alpha    = (s1_item_ff.flags.first_col ? '0 : q_ff.alpha) + (ext_a <<< 2) + ext_a;
      q_in.gray     = ext_g;
      q_in.alpha    = ext_a;
      tail_in       = s1_item_ff.flags.last_col ? p_in : tail_ff;

      out_in.bw_pixel   = g_res.bit_out && a_res.bit_out;
      out_in.opaque_bit = a_res.bit_out;
      out_in.tile_done  = s1_item_ff.flags.tile_done;
      out_valid_in      = advance || (out_valid_ff && !rsp_pop);
      rsp_item          = out_ff;
      rsp_empty         = !out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_item_ff  <= q_item;
         s1_col_ff   <= rd_addr;
         rd_ff       <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         eprev_ff.gray  <= g_res.err;
         eprev_ff.alpha <= a_res.err;
         p_ff           <= p_in;
         q_ff           <= q_in;
         tail_ff        <= tail_in;
         out_ff         <= out_in;
      end
   end

   `TFSD_CHECK_NEXT(a_result_follows_compute, advance, out_valid_ff,
      "computed pixel did not reach the result register")
   `TFSD_CHECK_NOW(a_done_only_on_last_col, advance && s1_item_ff.flags.tile_done,
      s1_item_ff.flags.last_col, "tile end flagged off the last column")
   `TFSD_CHECK_NOW(a_row_spans_two_cols, advance && s1_item_ff.flags.last_col,
      !s1_item_ff.flags.first_col, "row shorter than two pixels")
   `TFSD_CHECK_NEXT(a_err_in_range, advance,
      (eprev_ff.gray <= 127) && (eprev_ff.gray >= -127) &&
      (eprev_ff.alpha <= 127) && (eprev_ff.alpha >= -127),
      "quantization error out of range")

endmodule

`default_nettype wire

@@ sv/tiled_floyd_steinberg_dither_unit.sv @@
// Tiled Floyd-Steinberg dither unit: 8-bit gray and alpha pixels in, one
// bit each out, gray forced black where alpha dithers to transparent.
// Pixels of each square tile arrive in raster order, tile after tile; the
// error rows restart at every tile. The unit takes one pixel per clock while
// the queue has room and the result register is free or being popped; each
// pixel passes through the queue, the stage register and the result register,
// and its error is fed back through a register to its right neighbor; one
// error line memory of MAX_TILE entries carries the error to the next row.
// Writing the tile size (clamped to 2..MAX_TILE) restarts the tile.
// Uses tfsd_pkg, tfsd_front, tfsd_queue and tfsd_back.
`timescale 1ns / 1ps
`default_nettype none

module tiled_floyd_steinberg_dither_unit import tfsd_pkg::*; #(
   parameter int MAX_TILE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_item_type     req_item,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_item_type     rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_wdata
);

   logic       q_push, q_full, q_valid, q_pop;
   q_item_type q_in_item, q_out_item;

   tfsd_front #(
      .MAX_TILE (MAX_TILE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .q_push    (q_push),
      .q_item    (q_in_item),
      .q_full    (q_full)
   );

   tfsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_out_item),
      .valid     (q_valid)
   );

   tfsd_back #(
      .MAX_TILE (MAX_TILE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_item    (q_out_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// testbench for tiled_floyd_steinberg_dither_unit: pixels go in as queue pushes, results are
// popped and compared against an in-bench model of the tiled dither and its tile position
// depends on tfsd_pkg and the dither unit rtl
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import tfsd_pkg::*;

   localparam int MAX_TILE      = 64;
   localparam int ROW_SLOTS     = MAX_TILE + 2;
   localparam int THRESHOLD     = 127;
   localparam int WHITE         = 255;
   localparam int PIPE_LAT      = 3;
   localparam int DRAIN_CYCLES  = 4 * PIPE_LAT + 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PIXELS = 1950;
   localparam int GRAY_CH       = 0;
   localparam int ALPHA_CH      = 1;

   logic             clock;
   logic             reset;
   logic             req_push;
   req_item_type     req_item;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop;
   rsp_item_type     rsp_item;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_wdata;

   // model of the tile position and the weighted error rows, per channel
   logic [CSR_W-1:0] tile_reg;
   int               err_now[2][ROW_SLOTS];
   int               err_next[2][ROW_SLOTS];
   int unsigned      col_at;
   int unsigned      row_at;

   rsp_item_type     expected_bits[$];
   int               mismatches;
   int unsigned      sent_pixels;
   int unsigned      cycle_count;
   bit               steady_flow;

   tiled_floyd_steinberg_dither_unit #(
      .MAX_TILE(MAX_TILE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_item(req_item),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned tile_edge();
      if (tile_reg < MIN_TILE) return MIN_TILE;
      if (tile_reg > MAX_TILE) return MAX_TILE;
      return 32'(tile_reg);
   endfunction

   function automatic bit dither_level(input int ch, input int level, input int unsigned c);
      int want;
      int outv;
      int e;
      want = level + err_now[ch][c+1] / 16;
      outv = (want > THRESHOLD) ? WHITE : 0;
      e    = want - outv;
      err_now[ch][c+2]  += e * 7;
      err_next[ch][c]   += e * 3;
      err_next[ch][c+1] += e * 5;
      err_next[ch][c+2] += e;
      return outv != 0;
   endfunction

   function automatic rsp_item_type predict_pixel(input req_item_type px);
      int unsigned  ts;
      int unsigned  c;
      int unsigned  r;
      rsp_item_type res;
      ts = tile_edge();
      c  = col_at;
      r  = row_at;
      if (c >= ts || r >= ts) begin
         c = 0;
         r = 0;
      end
      if (c == 0 && r == 0) begin
         foreach (err_now[ch, k]) err_now[ch][k] = 0;
      end
      if (c == 0) begin
         foreach (err_next[ch, k]) err_next[ch][k] = 0;
      end
      res.bw_pixel   = dither_level(GRAY_CH, int'(px.gray_level), c);
      res.opaque_bit = dither_level(ALPHA_CH, int'(px.alpha_level), c);
      if (!res.opaque_bit) res.bw_pixel = 1'b0;
      res.tile_done = (c == ts - 1 && r == ts - 1);
      if (c == ts - 1) begin
         err_now = err_next;
         c = 0;
         r = (r == ts - 1) ? 0 : r + 1;
      end else begin
         c++;
      end
      col_at = c;
      row_at = r;
      return res;
   endfunction

   function automatic int draw_wait();
      if (steady_flow) return 0;
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [LEVEL_W-1:0] rand_level(input int style);
      case (style)
         1: begin
            return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
         end
         2: begin
            return LEVEL_W'($urandom_range(112, 143));
         end
         3: begin
            return LEVEL_W'(($urandom_range(0, 3) != 0) ? $urandom_range(200, 255)
                                                        : $urandom_range(0, 60));
         end
         default: begin
            return LEVEL_W'($urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   task automatic send_pixel(input logic [LEVEL_W-1:0] g, input logic [LEVEL_W-1:0] a);
      int           gap;
      req_item_type px;
      px.gray_level  = g;
      px.alpha_level = a;
      gap = draw_wait();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= px;
      @(posedge clock);
      while (req_full !== 1'b0) @(posedge clock);
      expected_bits.push_back(predict_pixel(px));
      sent_pixels++;
   endtask

   // only written once every pending transaction has drained
   task automatic write_tile_size(input logic [CSR_W-1:0] v);
      req_push <= 1'b0;
      while (expected_bits.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      tile_reg = v;
      col_at   = 0;
      row_at   = 0;
   endtask

   task automatic test_reset_tile();
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd255, 8'd255);
      send_pixel(8'd127, 8'd255);
      send_pixel(8'd128, 8'd255);
      send_pixel(8'd255, 8'd0);
      send_pixel(8'd200, 8'd127);
   endtask

   task automatic test_two_pixel_tile();
      write_tile_size(7'd2);
      send_pixel(8'd128, 8'd128);
      send_pixel(8'd127, 8'd200);
      send_pixel(8'd255, 8'd255);
      send_pixel(8'd0, 8'd255);
      send_pixel(8'd64, 8'd192);
   endtask

   task automatic test_size_clamp();
      write_tile_size(7'd0);
      send_pixel(8'd255, 8'd255);
      send_pixel(8'd10, 8'd250);
      write_tile_size(7'd127);
      send_pixel(8'd255, 8'd255);
      send_pixel(8'd255, 8'd255);
   endtask

   task automatic test_restart_mid_tile();
      write_tile_size(7'd3);
      repeat (3) send_pixel(8'd100, 8'd180);
      write_tile_size(7'd3);
      repeat (9) send_pixel(LEVEL_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)));
   endtask

   task automatic test_random_stream();
      int unsigned      goal;
      int unsigned      ts;
      int unsigned      count;
      int unsigned      pick;
      int               style;
      logic [CSR_W-1:0] raw;
      goal = sent_pixels + RANDOM_PIXELS;
      while (sent_pixels < goal) begin
         steady_flow = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick < 14) raw = CSR_W'($urandom_range(2, 12));
         else if (pick < 16) raw = 7'd2;
         else if (pick < 17) raw = CSR_W'(MAX_TILE);
         else if (pick < 18) raw = CSR_W'($urandom_range(0, 1));
         else if (pick < 19) raw = CSR_W'($urandom_range(MAX_TILE + 1, 127));
         else raw = CSR_W'($urandom_range(13, MAX_TILE - 1));
         if ($urandom_range(0, 4) != 0) write_tile_size(raw);
         ts = tile_edge();
         count = (ts > 12) ? $urandom_range(ts, 3 * ts) : $urandom_range(1, 3 * ts * ts);
         if (count > goal - sent_pixels) count = goal - sent_pixels;
         style = $urandom_range(0, 3);
         repeat (count) send_pixel(rand_level(style), rand_level(style));
      end
      steady_flow = 1'b0;
   endtask

   // result side: pop with random stalls and compare each transaction
   initial begin : rsp_side
      int           stall;
      rsp_item_type want;
      rsp_pop <= 1'b0;
      @(negedge reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty !== 1'b0) @(posedge clock);
         if (expected_bits.size() == 0) begin
            flag_mismatch("result with no pixel pending");
         end else begin
            want = expected_bits.pop_front();
            if (rsp_item.bw_pixel !== want.bw_pixel)
               flag_mismatch($sformatf("bw_pixel got %b want %b",
                                       rsp_item.bw_pixel, want.bw_pixel));
            if (rsp_item.opaque_bit !== want.opaque_bit)
               flag_mismatch($sformatf("opaque_bit got %b want %b",
                                       rsp_item.opaque_bit, want.opaque_bit));
            if (rsp_item.tile_done !== want.tile_done)
               flag_mismatch($sformatf("tile_done got %b want %b",
                                       rsp_item.tile_done, want.tile_done));
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_item  <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      mismatches  = 0;
      sent_pixels = 0;
      steady_flow = 1'b0;
      tile_reg    = CSR_W'(TILE_RESET);
      col_at      = 0;
      row_at      = 0;
      foreach (err_now[ch, k]) err_now[ch][k] = 0;
      foreach (err_next[ch, k]) err_next[ch][k] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_tile();
      test_two_pixel_tile();
      test_size_clamp();
      test_restart_mid_tile();
      test_random_stream();
      req_push <= 1'b0;
      while (expected_bits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
